// ===== hdl/hpsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsm_pkg: shared types and constants for the hall-pulse speed meter
// Operation codes, register indexes and the front-to-back job record.
// ----------------------------------------------------------------------------
package hpsm_pkg;

  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] REG_PPR     = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_MINGAP  = 2'd2;

  localparam logic [31:0] US_PER_MIN = 32'd60000000;
  localparam int          RPM_W      = 20;
  localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};

  // kind of speed job the front hands to the back
  typedef enum logic [1:0] {
    JOB_TOUT = 2'd0,
    JOB_DIV  = 2'd1,
    JOB_HOLD = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [3:0]  ch;
    logic [15:0] pulses;
    logic [31:0] span;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_MUL  = 3'd1,
    BK_DIV  = 3'd2,
    BK_HIST = 3'd3,
    BK_SUM  = 3'd4,
    BK_AVG  = 3'd5,
    BK_OUT  = 3'd6
  } bk_state_t;

endpackage

// ===== hdl/hall_pulse_mt_speed_meter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_pulse_mt_speed_meter_core: six-channel hall speed meter (M/T method)
// Usage: in_operation 0 records a hall edge (no result), 1 requests a speed
// sample, which yields one transfer on the out_ channel. Out-of-range channels
// are dropped. Edges are handled by the front alone; samples are queued (two
// deep) for the back. A sample that needs a division passes the queue and
// take-over, the operand multiply, a 50-step shift-subtract divider plus a
// finishing step, a history write, a read of the WINDOW history entries from
// RAM and an averaging step before out_valid rises. Timed-out, zero-span and
// no-pulse samples skip the divider. The back takes a new sample only once
// its last result has been taken. Reset (synchronous, rst_n low) restores
// the registers to 90 / 150000 / 1000 and clears edge state; history entries
// read as zero until written. When the receiver stalls the result holds on
// out_; the queue takes up to two more samples, then in_ready drops for
// edges and samples alike. The user writes configuration over cfg_ only when
// the block is idle; the block does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
module hall_pulse_mt_speed_meter_core #(
  parameter int CHANNELS      = 6,
  parameter int WINDOW        = 5,
  parameter int RPM_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [2:0]  in_channel,
  input  logic [31:0] in_time_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_channel,
  output logic [19:0] out_raw_rpm,
  output logic [19:0] out_filtered_rpm,
  output logic        out_timed_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import hpsm_pkg::*;

  logic [9:0]  ppr_r;
  logic [23:0] tout_r;
  logic [15:0] gap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r  <= 10'd90;
      tout_r <= 24'd150000;
      gap_r  <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PPR:     ppr_r  <= cfg_data[9:0];
        REG_TIMEOUT: tout_r <= cfg_data;
        REG_MINGAP:  gap_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic job_v, job_r_dy, q_v, q_rdy;
  job_t job_f, job_q;

  hpsm_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .operation(in_operation), .channel(in_channel), .time_us(in_time_us),
    .timeout_us(tout_r), .min_gap_us(gap_r),
    .job_valid(job_v), .job_ready(job_r_dy), .job(job_f)
  );

  hpsm_queue u_queue (
    .clk, .rst_n, .wr_valid(job_v), .wr_ready(job_r_dy), .wr_data(job_f),
    .rd_valid(q_v), .rd_ready(q_rdy), .rd_data(job_q)
  );

  hpsm_back #(.CHANNELS(CHANNELS), .WINDOW(WINDOW), .RPM_FRAC_BITS(RPM_FRAC_BITS)) u_back (
    .clk, .rst_n, .job_valid(q_v), .job_ready(q_rdy), .job(job_q),
    .ppr(ppr_r), .out_valid, .out_ready, .out_channel,
    .raw_rpm(out_raw_rpm), .filtered_rpm(out_filtered_rpm), .timed_out(out_timed_out)
  );

  // a timed-out result always reports zero speed
  a_tout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_raw_rpm == '0)
    else $error("timed out with nonzero rpm");

  // reported channel is always in range
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_channel} < 4'(CHANNELS))
    else $error("channel out of range");

  // edges never stall the input while the queue has room
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    job_r_dy |-> in_ready)
    else $error("input stalled with queue space");
endmodule

// ===== hdl/hpsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hpsm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/hpsm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsm_front: edge bookkeeping and sample classification
// Keeps per-channel edge times and counts; turns a sample into a job.
// ----------------------------------------------------------------------------
module hpsm_front #(
  parameter int CHANNELS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [2:0]          channel,
  input  logic [31:0]         time_us,
  input  logic [23:0]         timeout_us,
  input  logic [15:0]         min_gap_us,
  output logic                job_valid,
  input  logic                job_ready,
  output hpsm_pkg::job_t      job
);
  import hpsm_pkg::*;

  logic [15:0] cnt_r   [CHANNELS];
  logic [31:0] first_r [CHANNELS];
  logic [31:0] last_r  [CHANNELS];
  logic [31:0] prev_r  [CHANNELS];

  logic        ch_ok;
  logic [31:0] since;
  logic [31:0] span;
  job_t        j;

  assign in_ready = job_ready;
  assign ch_ok    = {1'b0, channel} < 4'(CHANNELS);

  always_comb begin
    since    = 32'd0;
    span     = 32'd0;
    j        = '0;
    j.ch     = {1'b0, channel};
    j.kind   = JOB_HOLD;
    if (ch_ok) begin
      since = time_us - last_r[channel];
      if (cnt_r[channel] >= 16'd2) begin
        span = last_r[channel] - first_r[channel];
      end else begin
        span = last_r[channel] - prev_r[channel];
      end
      j.span   = span;
      j.pulses = (cnt_r[channel] >= 16'd2) ? cnt_r[channel] - 16'd1 : 16'd1;
      if (since > {8'd0, timeout_us}) begin
        j.kind = JOB_TOUT;
      end else if (cnt_r[channel] != 16'd0) begin
        j.kind = JOB_DIV;
      end
    end
  end

  assign job       = j;
  assign job_valid = in_valid && ch_ok && operation == OP_SAMPLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i]   <= '0;
        first_r[i] <= '0;
        last_r[i]  <= '0;
        prev_r[i]  <= '0;
      end
    end else if (in_valid && in_ready && ch_ok) begin
      if (operation == OP_EDGE) begin
        if (since > {16'd0, min_gap_us}) begin
          if (cnt_r[channel] == 16'd0) begin
            first_r[channel] <= time_us;
          end
          prev_r[channel] <= last_r[channel];
          last_r[channel] <= time_us;
          if (cnt_r[channel] != 16'hFFFF) begin
            cnt_r[channel] <= cnt_r[channel] + 16'd1;
          end
        end
      end else begin
        cnt_r[channel] <= '0;
      end
    end
  end
endmodule

// ===== hdl/hpsm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsm_queue: two-entry job queue between front and back
// ----------------------------------------------------------------------------
module hpsm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  hpsm_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output hpsm_pkg::job_t rd_data
);
  import hpsm_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== hdl/hpsm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsm_back: speed computation, history and averaging
// Shift-subtract divider, per-channel history in RAM, serial window sum.
// ----------------------------------------------------------------------------
module hpsm_back #(
  parameter int CHANNELS      = 6,
  parameter int WINDOW        = 5,
  parameter int RPM_FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  hpsm_pkg::job_t job,
  input  logic [9:0]     ppr,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_channel,
  output logic [19:0]    raw_rpm,
  output logic [19:0]    filtered_rpm,
  output logic           timed_out
);
  import hpsm_pkg::*;

  localparam int POS_W  = $clog2(WINDOW);
  localparam int CH_W   = $clog2(CHANNELS) > 0 ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int NUM_W  = 16 + 26 + RPM_FRAC_BITS;  // pulses*60e6<<F
  localparam int DEN_W  = 42;
  localparam int CMP_W  = DEN_W + 1;
  localparam int SUM_W  = RPM_W + 4;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  // floor(sum / WINDOW) as (sum * REC_M) >> REC_SH, exact for sum < 2^SUM_W
  localparam int     REC_SH = SUM_W + $clog2(WINDOW);
  localparam longint REC_M  = ((64'd1 << REC_SH) + WINDOW - 1) / WINDOW;
  localparam int     PROD_W = 2 * SUM_W + 1;

  bk_state_t st_r, st_nxt;

  job_t               job_r;
  logic [NUM_W-1:0]   quo_r;
  logic [DEN_W-1:0]   rem_r, den_r;
  logic [CNT_W-1:0]   bit_r;
  logic [RPM_W-1:0]   raw_r;
  logic [SUM_W-1:0]   sum_r;
  logic [POS_W:0]     idx_r;
  logic [POS_W-1:0]   pos_r [CHANNELS];
  logic [WINDOW-1:0]  wr_r  [CHANNELS];   // history entry written since reset
  logic               tout_r;
  logic [19:0]        filt_r;

  // RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_wa, ram_ra;
  logic [RPM_W-1:0]  ram_wd, ram_rd;
  logic [POS_W-1:0]  cur_pos, prev_pos, rd_pos, rd_cur;
  logic [CH_W-1:0]   chi, rd_ch;
  logic              rd_ok_r;
  logic [PROD_W-1:0] avg_prod;

  hpsm_ram #(.WIDTH(RPM_W), .DEPTH(DEPTH)) u_hist (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  assign chi      = job_r.ch[CH_W-1:0];
  assign cur_pos  = pos_r[chi];
  // while idle, read ahead for the job being taken so MUL sees its last entry
  assign rd_ch    = (st_r == BK_IDLE) ? job.ch[CH_W-1:0] : chi;
  assign rd_cur   = pos_r[rd_ch];
  assign prev_pos = (rd_cur == '0) ? POS_W'(WINDOW - 1) : rd_cur - 1'b1;

  always_comb begin
    rd_pos = POS_W'(idx_r);
    if (st_r == BK_IDLE || st_r == BK_MUL || st_r == BK_DIV) begin
      rd_pos = prev_pos;
    end
    ram_ra = ADDR_W'(rd_ch * WINDOW) + ADDR_W'(rd_pos);
    ram_we = st_r == BK_HIST;
    ram_wa = ADDR_W'(chi * WINDOW) + ADDR_W'(cur_pos);
    ram_wd = raw_r;
  end

  // unused-entry masking: never-written history reads as zero
  logic [RPM_W-1:0] hist_val;
  assign hist_val = rd_ok_r ? ram_rd : '0;

  logic [CMP_W-1:0] trial;
  logic [DEN_W-1:0] rem_sh;
  assign rem_sh = {rem_r[DEN_W-2:0], quo_r[NUM_W-1]};
  assign trial  = {rem_r[DEN_W-1], rem_sh} - {1'b0, den_r};

  assign avg_prod = {{(SUM_W + 1){1'b0}}, sum_r} * PROD_W'(REC_M);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (job_valid) st_nxt = BK_MUL;
      BK_MUL:  st_nxt = (job_r.kind == JOB_DIV && ppr != '0 && job_r.span != '0) ?
                        BK_DIV : BK_HIST;
      BK_DIV:  if (bit_r == '0) st_nxt = BK_HIST;
      BK_HIST: st_nxt = BK_SUM;
      BK_SUM:  if (idx_r == (POS_W+1)'(WINDOW)) st_nxt = BK_AVG;
      BK_AVG:  st_nxt = BK_OUT;
      BK_OUT:  if (out_ready) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = st_r == BK_IDLE;
    out_valid = st_r == BK_OUT;
  end

  assign out_channel  = job_r.ch[2:0];
  assign raw_rpm      = raw_r;
  assign filtered_rpm = filt_r;
  assign timed_out    = tout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c] <= '0;
        wr_r[c]  <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_HIST) begin
        pos_r[chi] <= (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
        wr_r[chi][cur_pos] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= wr_r[rd_ch][rd_pos];
    unique case (st_r)
      BK_IDLE: begin
        job_r <= job;
      end
      BK_MUL: begin
        // registered multiplies: numerator and denominator
        quo_r  <= NUM_W'({({26'd0, job_r.pulses} * {10'd0, US_PER_MIN}),
                          RPM_FRAC_BITS'(0)});
        den_r  <= {32'd0, ppr} * {10'd0, job_r.span};
        rem_r  <= '0;
        bit_r  <= CNT_W'(NUM_W);
        tout_r <= job_r.kind == JOB_TOUT;
        raw_r  <= job_r.kind == JOB_HOLD ? hist_val : '0;
      end
      BK_DIV: begin
        if (bit_r == '0) begin
          raw_r <= (|quo_r[NUM_W-1:RPM_W]) ? RPM_MAX : quo_r[RPM_W-1:0];
        end else begin
          bit_r <= bit_r - 1'b1;
          if (!trial[CMP_W-1]) begin
            rem_r <= trial[DEN_W-1:0];
            quo_r <= {quo_r[NUM_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[NUM_W-2:0], 1'b0};
          end
        end
      end
      BK_HIST: begin
        idx_r <= '0;
        sum_r <= '0;
      end
      BK_SUM: begin
        // read data arrives in the cycle after its address
        idx_r <= idx_r + 1'b1;
        if (idx_r >= (POS_W+1)'(1)) begin
          sum_r <= sum_r + SUM_W'(hist_val);
        end
      end
      BK_AVG: filt_r <= avg_prod[REC_SH +: RPM_W];
      BK_OUT: ;
      default: ;
    endcase
  end
endmodule

// ===== dv/hall_pulse_mt_speed_meter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_pulse_mt_speed_meter_core_tb: self-checking bench for the speed meter
// Feeds hall edges and sample requests through a queue-fed driver. It keeps
// its own copy of the per-channel edge state and rpm history, and works out
// the expected rpm for every accepted in-range sample. A monitor compares each result
// transfer field by field. The run starts with directed cases, then moves
// through several register settings with random edge trains and samples.
// ----------------------------------------------------------------------------
module hall_pulse_mt_speed_meter_core_tb;
  import hpsm_pkg::*;

  localparam int          NCH       = 6;
  localparam int          WIN       = 5;
  localparam int          FRAC      = 8;
  localparam logic [1:0]  REG_SPARE = 2'd3;  // unmapped index, must be ignored
  localparam int          SETTLE    = 200;   // longer than two queued samples take to finish
  localparam int          STALL_MAX = 5000;

  typedef struct {
    logic        op;
    logic [2:0]  ch;
    logic [31:0] t;
  } hall_item_t;

  typedef struct {
    logic [2:0]  ch;
    logic [19:0] raw;
    logic [19:0] filt;
    logic        tout;
  } speed_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [2:0]  in_channel;
  logic [31:0] in_time_us;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_channel;
  logic [19:0] out_raw_rpm;
  logic [19:0] out_filtered_rpm;
  logic        out_timed_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  hall_pulse_mt_speed_meter_core dut (.*);

  // local copy of the block's registers and per-channel state
  logic [9:0]  ppr_q;
  logic [23:0] tmo_q;
  logic [15:0] gap_q;
  logic [15:0] cnt_q   [NCH];
  logic [31:0] first_q [NCH];
  logic [31:0] last_q  [NCH];
  logic [31:0] prev_q  [NCH];
  logic [19:0] hist_q  [NCH][WIN];
  int          hpos_q  [NCH];

  hall_item_t  pending_items[$];
  speed_rec_t  expected_speeds[$];
  hall_item_t  cur_item;
  int          idle_left;
  int          stall_left;
  bit          idle_on;
  int          errors;
  int          quiet_cycles;

  always #5 clk = ~clk;

  // M/T quotient: pulses * 60e6 * 2^F / (ppr * span), saturating
  function automatic logic [19:0] mt_rpm(input logic [31:0] pulses, input logic [31:0] span);
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    if (span == 0 || ppr_q == 0) return '0;
    num = (longint'(pulses) * 64'd60000000) << FRAC;
    den = longint'(ppr_q) * longint'(span);
    q   = num / den;
    return (q > 64'hFFFFF) ? RPM_MAX : q[19:0];
  endfunction

  // apply one accepted item to the local state; samples queue an expectation
  task automatic track_item(input hall_item_t it);
    speed_rec_t r;
    logic [15:0] n;
    int p;
    int unsigned sum;
    if (it.ch >= NCH) return;
    if (it.op == OP_EDGE) begin
      if (it.t - last_q[it.ch] > {16'd0, gap_q}) begin
        if (cnt_q[it.ch] == 0) first_q[it.ch] = it.t;
        prev_q[it.ch] = last_q[it.ch];
        last_q[it.ch] = it.t;
        if (cnt_q[it.ch] != 16'hFFFF) cnt_q[it.ch]++;
      end
      return;
    end
    n = cnt_q[it.ch];
    cnt_q[it.ch] = 0;
    p = hpos_q[it.ch];
    r.ch = it.ch;
    r.tout = 1'b0;
    if (it.t - last_q[it.ch] > {8'd0, tmo_q}) begin
      r.raw = '0;
      r.tout = 1'b1;
    end else if (n >= 2) begin
      r.raw = mt_rpm(n - 1, last_q[it.ch] - first_q[it.ch]);
    end else if (n == 1) begin
      r.raw = mt_rpm(1, last_q[it.ch] - prev_q[it.ch]);
    end else begin
      r.raw = hist_q[it.ch][(p + WIN - 1) % WIN];
    end
    hist_q[it.ch][p] = r.raw;
    hpos_q[it.ch] = (p + 1) % WIN;
    sum = 0;
    for (int i = 0; i < WIN; i++) sum += hist_q[it.ch][i];
    r.filt = 20'(sum / WIN);
    expected_speeds.push_back(r);
  endtask

  // driver: one transfer per handshake, idle bursts between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && in_ready) track_item(cur_item);
      if (!(in_valid && !in_ready)) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(1, 14) - 1;
            in_valid <= 1'b0;
          end else begin
            cur_item = pending_items.pop_front();
            in_valid     <= 1'b1;
            in_operation <= cur_item.op;
            in_channel   <= cur_item.ch;
            in_time_us   <= cur_item.t;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stalls in bursts, checks every result transfer
  always @(posedge clk) begin
    speed_rec_t e;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_speeds.size() == 0) begin
          $error("result transfer with nothing expected, channel %0d", out_channel);
          errors++;
        end else begin
          e = expected_speeds.pop_front();
          if (out_channel !== e.ch) begin
            $error("out_channel: expected %0d, got %0d", e.ch, out_channel);
            errors++;
          end
          if (out_raw_rpm !== e.raw) begin
            $error("raw_rpm: expected %0d, got %0d", e.raw, out_raw_rpm);
            errors++;
          end
          if (out_filtered_rpm !== e.filt) begin
            $error("filtered_rpm: expected %0d, got %0d", e.filt, out_filtered_rpm);
            errors++;
          end
          if (out_timed_out !== e.tout) begin
            $error("timed_out: expected %0d, got %0d", e.tout, out_timed_out);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: trips when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("hall_pulse_mt_speed_meter_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PPR:     ppr_q = val[9:0];
      REG_TIMEOUT: tmo_q = val;
      REG_MINGAP:  gap_q = val[15:0];
      default:     ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(input logic op, input logic [2:0] ch, input logic [31:0] t);
    hall_item_t it;
    it.op = op;
    it.ch = ch;
    it.t  = t;
    pending_items.push_back(it);
  endtask

  // wait for every queued item to go and every expected result to arrive
  task automatic drain;
    do @(posedge clk); while (pending_items.size() > 0 || in_valid);
    while (expected_speeds.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random edge trains on a running clock, with samples and some noise
  task automatic random_items(input int n, input int step);
    logic [31:0] tnow;
    int done;
    int pick;
    tnow = $urandom;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        tnow += $urandom_range(0, step);
        push_item(OP_EDGE, $urandom_range(0, NCH - 1), tnow);
        done++;
      end else if (pick < 90) begin
        tnow += $urandom_range(0, step);
        push_item(OP_SAMPLE, $urandom_range(0, NCH - 1), tnow);
        done++;
      end else if (pick < 95) begin
        push_item($urandom_range(0, 1), $urandom_range(NCH, 7), $urandom);
      end else begin
        push_item($urandom_range(0, 1), $urandom_range(0, NCH - 1), $urandom);
        done++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_channel = '0;
    in_time_us = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    quiet_cycles = 0;
    idle_left = 0;
    stall_left = 0;
    idle_on = 1'b1;
    ppr_q = 10'd90;
    tmo_q = 24'd150000;
    gap_q = 16'd1000;
    for (int c = 0; c < NCH; c++) begin
      cnt_q[c] = 0; first_q[c] = 0; last_q[c] = 0; prev_q[c] = 0; hpos_q[c] = 0;
      for (int i = 0; i < WIN; i++) hist_q[c][i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings
    push_item(OP_SAMPLE, 3'd0, 32'd0);           // no pulses, history still clear
    push_item(OP_EDGE,   3'd0, 32'd500);         // inside min gap: dropped
    push_item(OP_EDGE,   3'd0, 32'd1001);
    push_item(OP_SAMPLE, 3'd0, 32'd2000);        // single pulse, uses last interval
    push_item(OP_EDGE,   3'd1, 32'd10000);
    push_item(OP_EDGE,   3'd1, 32'd20000);
    push_item(OP_EDGE,   3'd1, 32'd30000);
    push_item(OP_SAMPLE, 3'd1, 32'd30500);       // multi pulse
    push_item(OP_SAMPLE, 3'd1, 32'd31000);       // no pulses: repeats last raw
    push_item(OP_EDGE,   3'd6, 32'd40000);       // out-of-range channels
    push_item(OP_SAMPLE, 3'd7, 32'd40000);
    push_item(OP_SAMPLE, 3'd3, 32'hFFFF_FFFF);   // timed out
    push_item(OP_EDGE,   3'd4, 32'hFFFF_F000);   // train across the wrap
    push_item(OP_EDGE,   3'd4, 32'h0000_0800);
    push_item(OP_SAMPLE, 3'd4, 32'h0000_0900);
    push_item(OP_EDGE,   3'd2, 32'h0000_0010);   // wrap: first edge dropped, span of 2^31 us
    push_item(OP_EDGE,   3'd2, 32'h8000_0010);
    push_item(OP_EDGE,   3'd2, 32'h0000_0010);
    push_item(OP_SAMPLE, 3'd2, 32'h0000_0010);
    drain();

    // extremes: ppr 1, longest timeout, no gap -> saturation
    write_reg(REG_PPR, 24'd1);
    write_reg(REG_TIMEOUT, 24'hFFFFFF);
    write_reg(REG_MINGAP, 24'd0);
    write_reg(REG_SPARE, 24'hABCDEF);
    push_item(OP_EDGE, 3'd5, 32'd100);
    push_item(OP_EDGE, 3'd5, 32'd101);
    push_item(OP_EDGE, 3'd5, 32'd102);
    push_item(OP_SAMPLE, 3'd5, 32'd103);
    for (int i = 0; i < 40; i++) push_item(OP_EDGE, 3'd0, 32'h0100_0000 + i);
    push_item(OP_SAMPLE, 3'd0, 32'h0100_0000 + 40);
    drain();

    // ppr written as zero through its masked bits, widest gap, shortest timeout
    write_reg(REG_PPR, 24'h000400);
    write_reg(REG_MINGAP, 24'hFFFFFF);
    write_reg(REG_TIMEOUT, 24'd1);
    push_item(OP_EDGE, 3'd1, 32'h0010_0000);
    push_item(OP_EDGE, 3'd1, 32'h0020_0000);
    push_item(OP_SAMPLE, 3'd1, 32'h0020_0000);
    push_item(OP_SAMPLE, 3'd1, 32'h0020_0002);
    drain();
    write_reg(REG_TIMEOUT, 24'hFFFFFF);
    write_reg(REG_PPR, 24'd1023);
    push_item(OP_EDGE, 3'd3, 32'h0300_0000);
    push_item(OP_SAMPLE, 3'd3, 32'h0300_0000);
    drain();

    // random settings, last one without idling
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_PPR, $urandom_range(1, 1023));
      write_reg(REG_TIMEOUT, (ph % 2) ? $urandom_range(1, 6000) : $urandom_range(1, 24'hFFFFFF));
      write_reg(REG_MINGAP, $urandom_range(0, 2500));
      if (ph == 3) idle_on = 1'b0;
      random_items(250, 4000);
      drain();
    end

    if (errors == 0 && expected_speeds.size() == 0) begin
      $display("hall_pulse_mt_speed_meter_core_tb OK");
    end else begin
      $display("hall_pulse_mt_speed_meter_core_tb NOT OK");
    end
    $finish;
  end

endmodule
